### src/cdate_pkg.sv
// Shared types, constants and helper functions for the calendar date counter.
`timescale 1ns / 1ps

package cdate_pkg;

    // Operation codes
    localparam logic [2:0] OP_LOAD      = 3'd0;
    localparam logic [2:0] OP_ADD_DAY   = 3'd1;
    localparam logic [2:0] OP_ADD_MONTH = 3'd2;
    localparam logic [2:0] OP_ADD_YEAR  = 3'd3;
    localparam logic [2:0] OP_NEXT_MON  = 3'd4;

    // Weekday codes
    localparam logic [2:0] WD_SUNDAY = 3'd0;
    localparam logic [2:0] WD_MONDAY = 3'd1;
    localparam logic [2:0] WD_FRIDAY = 3'd5;

    // Date limits and reset date
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] YEAR_RESET = 14'd2021;
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_MAR  = 4'd3;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;

    // Reciprocals: floor(x * RECIP_100 >> 19) == x / 100 for x < 2^14,
    // floor(x * RECIP_7 >> 18) == x / 7 for x < 2^14.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [15:0] RECIP_7   = 16'd37450;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;      // take a new item, set up the working date
        logic q_load;     // register year / 100 of the selected operand
        logic mul_wd;     // operand select: 1 weekday year, 0 working year
        logic leap_load;  // register leap flag of working year
        logic adjust;     // load check or day clamp
        logic walk_step;  // advance working date one day
        logic sum_load;   // register weekday sum
        logic div_load;   // register sum / 7
        logic commit;     // write back the date and weekday
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_walk;    // item walks day by day
        logic walk_last;  // current walk step is the last one
    } t_stat;

    // Days in a month; leap selects February length
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Month term of the weekday sum
    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] off;
        case (m)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // Gregorian leap test given y and q = y / 100
    function automatic logic leap_of(input logic [13:0] y, input logic [7:0] q);
        logic [13:0] hund;
        logic        century;
        hund    = 14'(q) * 14'd100;
        century = (y == hund);
        return century ? (q[1:0] == 2'd0) : (y[1:0] == 2'd0);
    endfunction

endpackage

### src/calendar_date_counter.sv
// Top level of the Gregorian calendar date counter with weekday.
//
// Usage: drive i_operation and the i_load_* fields and raise start while busy
// is low; the item is taken at that clock edge. Operations are load, add one
// day, add one month, add one year and advance to the next Monday.
// Exactly one result follows each item: o_valid is high for one cycle and the
// o_cur_* date, o_weekday, o_leap_year, o_month_length and o_error are
// valid in that cycle. The receiver cannot stall; o_valid is not held.
// After acceptance each item passes a leap step (multiply, then check),
// then the load check or day clamp step for load, add month, add year and
// unused codes, or a day walk for add day (one day) and next Monday (one to
// seven days), then a final leap step. The walk advances one day per cycle and
// the weekday is found in four steps through a shared multiplier, a sum and a
// reciprocal multiply for the modulo 7. busy stays high from acceptance until
// the o_valid cycle, so items go one at a time: a new item waits for the last.
// A failed item (invalid load or year past 9999) keeps the stored date and
// reports o_error high. Reset sets the date to 2021-01-01, a Friday.
`timescale 1ns / 1ps

module calendar_date_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [13:0] i_load_year,
    input  logic [3:0]  i_load_month,
    input  logic [4:0]  i_load_day,
    output logic        o_valid,
    output logic [13:0] o_cur_year,
    output logic [3:0]  o_cur_month,
    output logic [4:0]  o_cur_day,
    output logic [2:0]  o_weekday,
    output logic        o_leap_year,
    output logic [4:0]  o_month_length,
    output logic        o_error
);
    import cdate_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    cdate_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_valid (o_valid)
    );

    // Date arithmetic
    cdate_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_load_year    (i_load_year),
        .i_load_month   (i_load_month),
        .i_load_day     (i_load_day),
        .o_cur_year     (o_cur_year),
        .o_cur_month    (o_cur_month),
        .o_cur_day      (o_cur_day),
        .o_weekday      (o_weekday),
        .o_leap_year    (o_leap_year),
        .o_month_length (o_month_length),
        .o_error        (o_error)
    );

endmodule

### src/cdate_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps

module cdate_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  cdate_pkg::t_stat i_stat,
    output cdate_pkg::t_cmd  o_cmd,
    output logic            o_valid
);
    import cdate_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEAP_MUL,
        S_LEAP_CHK,
        S_ADJUST,
        S_WALK,
        S_FIN_MUL,
        S_FIN_CHK,
        S_WD_MUL,
        S_WD_SUM,
        S_WD_DIV,
        S_WD_REM
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (start) n_state = S_LEAP_MUL;
            S_LEAP_MUL: n_state = S_LEAP_CHK;
            S_LEAP_CHK: n_state = i_stat.is_walk ? S_WALK : S_ADJUST;
            S_ADJUST:   n_state = S_FIN_MUL;
            S_WALK:     if (i_stat.walk_last) n_state = S_FIN_MUL;
            S_FIN_MUL:  n_state = S_FIN_CHK;
            S_FIN_CHK:  n_state = S_WD_MUL;
            S_WD_MUL:   n_state = S_WD_SUM;
            S_WD_SUM:   n_state = S_WD_DIV;
            S_WD_DIV:   n_state = S_WD_REM;
            S_WD_REM:   n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands decoded from state
    always_comb begin
        o_cmd           = '0;
        o_cmd.latch     = (r_state == S_IDLE) && start;
        o_cmd.q_load    = (r_state == S_LEAP_MUL) || (r_state == S_FIN_MUL) ||
                          (r_state == S_WD_MUL);
        o_cmd.mul_wd    = (r_state == S_WD_MUL);
        o_cmd.leap_load = (r_state == S_LEAP_CHK) || (r_state == S_FIN_CHK);
        o_cmd.adjust    = (r_state == S_ADJUST);
        o_cmd.walk_step = (r_state == S_WALK);
        o_cmd.sum_load  = (r_state == S_WD_SUM);
        o_cmd.div_load  = (r_state == S_WD_DIV);
        o_cmd.commit    = (r_state == S_WD_REM);
    end

    // State and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_WD_REM);
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

### src/cdate_dp.sv
// Datapath: stored date, working date, leap and weekday arithmetic.
`timescale 1ns / 1ps

module cdate_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cdate_pkg::t_cmd  i_cmd,
    output cdate_pkg::t_stat o_stat,
    input  logic [2:0]       i_operation,
    input  logic [13:0]      i_load_year,
    input  logic [3:0]       i_load_month,
    input  logic [4:0]       i_load_day,
    output logic [13:0]      o_cur_year,
    output logic [3:0]       o_cur_month,
    output logic [4:0]       o_cur_day,
    output logic [2:0]       o_weekday,
    output logic             o_leap_year,
    output logic [4:0]       o_month_length,
    output logic             o_error
);
    import cdate_pkg::*;

    // Stored date
    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [2:0]  r_wday;
    logic        r_leap;
    logic        r_err;

    // Working item
    logic [2:0]  r_op;
    logic [13:0] r_wk_year;
    logic [3:0]  r_wk_month;
    logic [4:0]  r_wk_day;
    logic        r_wk_leap;
    logic        r_fail;
    logic [2:0]  r_cnt;

    // Arithmetic pipeline registers
    logic [7:0]  r_q;
    logic [13:0] r_yy;
    logic [13:0] r_sum;
    logic [10:0] r_p;

    logic [13:0] mul_in;
    logic [26:0] prod_q;
    logic [29:0] prod_d;
    logic [13:0] year_inc;
    logic [2:0]  steps;
    logic [4:0]  wk_ml;
    logic        load_ok;
    logic [13:0] n_sum;
    logic [13:0] rem_full;

    // Shared year / 100 multiplier
    assign mul_in = i_cmd.mul_wd ? r_yy : r_wk_year;
    assign prod_q = 27'(mul_in) * 27'(RECIP_100);

    // Sum / 7 multiplier and remainder
    assign prod_d   = 30'(r_sum) * 30'(RECIP_7);
    assign rem_full = r_sum - (14'(r_p) * 14'd7);

    assign year_inc = r_year + 14'd1;
    assign wk_ml    = month_len(r_wk_month, r_wk_leap);

    // Days to the next Monday, strictly later
    always_comb begin
        if (r_wday == WD_SUNDAY) begin
            steps = 3'd1;
        end else if (r_wday == WD_MONDAY) begin
            steps = 3'd7;
        end else begin
            steps = 3'(4'd8 - 4'(r_wday));
        end
    end

    // Load validity
    assign load_ok = (r_wk_year != 14'd0) && (r_wk_year <= YEAR_MAX) &&
                     (r_wk_month != 4'd0) && (r_wk_month <= MONTH_DEC) &&
                     (r_wk_day != 5'd0) && (r_wk_day <= wk_ml);

    // Weekday sum: yy + yy/4 - yy/100 + yy/400 + month term + day
    assign n_sum = r_yy + (r_yy >> 2) - 14'(r_q) + 14'(r_q >> 2) +
                   14'(month_offset(r_wk_month)) + 14'(r_wk_day);

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op       <= i_operation;
            r_wk_year  <= r_year;
            r_wk_month <= r_month;
            r_wk_day   <= r_day;
            r_fail     <= 1'b0;
            r_cnt      <= 3'd1;
            case (i_operation)
                OP_LOAD: begin
                    r_wk_year  <= i_load_year;
                    r_wk_month <= i_load_month;
                    r_wk_day   <= i_load_day;
                end
                OP_NEXT_MON: begin
                    r_cnt <= steps;
                end
                OP_ADD_MONTH: begin
                    if (r_month == MONTH_DEC) begin
                        if (r_year >= YEAR_MAX) begin
                            r_fail <= 1'b1;
                        end else begin
                            r_wk_year  <= year_inc;
                            r_wk_month <= MONTH_JAN;
                        end
                    end else begin
                        r_wk_month <= r_month + 4'd1;
                    end
                end
                OP_ADD_YEAR: begin
                    if (r_year >= YEAR_MAX) begin
                        r_fail <= 1'b1;
                    end else begin
                        r_wk_year <= year_inc;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.q_load) begin
            r_q <= prod_q[26:19];
        end

        // Leap flag of working year, and the weekday year term
        if (i_cmd.leap_load) begin
            r_wk_leap <= leap_of(r_wk_year, r_q);
            r_yy      <= (r_wk_month < MONTH_MAR) ? (r_wk_year - 14'd1) : r_wk_year;
        end

        // Load check, or clamp day to the new month length
        if (i_cmd.adjust) begin
            if (r_op == OP_LOAD) begin
                if (!load_ok) begin
                    r_fail <= 1'b1;
                end
            end else if ((r_op == OP_ADD_MONTH) || (r_op == OP_ADD_YEAR)) begin
                if (r_wk_day > wk_ml) begin
                    r_wk_day <= wk_ml;
                end
            end
        end

        // One day forward; a walk never reaches February after a year roll
        if (i_cmd.walk_step) begin
            r_cnt <= r_cnt - 3'd1;
            if (!r_fail) begin
                if (r_wk_day >= wk_ml) begin
                    if (r_wk_month == MONTH_DEC) begin
                        if (r_wk_year >= YEAR_MAX) begin
                            r_fail <= 1'b1;
                        end else begin
                            r_wk_year  <= r_wk_year + 14'd1;
                            r_wk_month <= MONTH_JAN;
                            r_wk_day   <= DAY_FIRST;
                        end
                    end else begin
                        r_wk_month <= r_wk_month + 4'd1;
                        r_wk_day   <= DAY_FIRST;
                    end
                end else begin
                    r_wk_day <= r_wk_day + 5'd1;
                end
            end
        end

        if (i_cmd.sum_load) begin
            r_sum <= n_sum;
        end

        if (i_cmd.div_load) begin
            r_p <= prod_d[28:18];
        end
    end

    // Stored date, written back only when the item succeeds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= YEAR_RESET;
            r_month <= MONTH_JAN;
            r_day   <= DAY_FIRST;
            r_wday  <= WD_FRIDAY;
            r_leap  <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_cmd.commit) begin
            r_err <= r_fail;
            if (!r_fail) begin
                r_year  <= r_wk_year;
                r_month <= r_wk_month;
                r_day   <= r_wk_day;
                r_wday  <= rem_full[2:0];
                r_leap  <= r_wk_leap;
            end
        end
    end

    assign o_stat.is_walk   = (r_op == OP_ADD_DAY) || (r_op == OP_NEXT_MON);
    assign o_stat.walk_last = (r_cnt == 3'd1);

    assign o_cur_year     = r_year;
    assign o_cur_month    = r_month;
    assign o_cur_day      = r_day;
    assign o_weekday      = r_wday;
    assign o_leap_year    = r_leap;
    assign o_month_length = month_len(r_month, r_leap);
    assign o_error        = r_err;

endmodule
